@@ rtl/oaht_pkg.sv @@
// ----------------------------------------------------------------------------
// Open addressing hash table package
// Shared constants, operation codes and sequencer states of the hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

  // Default geometry of the table.
  localparam int SlotsDef     = 1024;
  localparam int KeyBitsDef   = 32;
  localparam int ValueBitsDef = 32;

  // Fixed widths of the port fields.
  localparam int OpW       = 2;
  localparam int DataW     = 32;
  localparam int SlotOutW  = 10;
  localparam int CountOutW = 11;
  localparam int SizeW     = 4;

  // Size register lower limit and reset value.
  localparam logic [SizeW-1:0] SizeLog2Reset = 4'd10;
  localparam logic [SizeW-1:0] SizeLog2Min   = 4'd2;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP = 2'd0,
    OP_SET    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_CHECK
  } state_e;

endpackage

`default_nettype wire

@@ rtl/open_addressing_hash_table_core.sv @@
// ----------------------------------------------------------------------------
// Open addressing hash table core
// Append-only key/value table with triangular probing over a power-of-two
// number of slots, built around one probe adder and one key comparator.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Signals                                  Handshake
// command    in         operation_i key_i key_hash_i value_i     start & !busy
// result     out        found_o slot_o value_out_o status_o      done_o, 1 cycle
//                       stored_count_o
// config     in         cfg_wdata_i (table_size_log2)            cfg_we_i
//
// A lookup or set reads one slot per probe: the memories are addressed in
// ST_READ and their registered data is compared in ST_CHECK, the cycle after,
// so an operation keeps busy high while it probes and strobes its word in the
// cycle after its last probe. A clear, and also the reset, runs a clearing pass
// over all SLOTS occupancy bits, one per cycle, with busy held high throughout.
// Operation code 3 answers in the cycle after it is accepted.
// The receiver cannot stall: each result word is shown for one cycle only,
// while the core is already free to take the next command word.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_table_core
  import oaht_pkg::*;
#(
  parameter int SLOTS      = SlotsDef,
  parameter int KEY_BITS   = KeyBitsDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Command word.
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [OpW-1:0]       operation_i,
  input  wire logic [DataW-1:0]     key_i,
  input  wire logic [DataW-1:0]     key_hash_i,
  input  wire logic [DataW-1:0]     value_i,
  // Result word.
  output logic                      done_o,
  output logic                      found_o,
  output logic [SlotOutW-1:0]       slot_o,
  output logic [DataW-1:0]          value_out_o,
  output logic                      status_o,
  output logic [CountOutW-1:0]      stored_count_o,
  // Size register.
  input  wire logic                 cfg_we_i,
  input  wire logic [SizeW-1:0]     cfg_wdata_i
);

  localparam int SlotW = $clog2(SLOTS);
  localparam int CntW  = $clog2(SLOTS + 1);

  // Storage. The occupancy bits are cleared by a sweep; keys and values are
  // only read from occupied slots, so they need no reset.
  logic                  occ_mem [SLOTS];
  logic [KEY_BITS-1:0]   key_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];

  logic                  occ_rd_q;
  logic [KEY_BITS-1:0]   key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;

  logic                  occ_we;
  logic [SlotW-1:0]      occ_wa;
  logic                  occ_wd;
  logic                  kv_we;
  logic                  val_we;

  // Control state.
  state_e              state_q, state_d;
  logic [SizeW-1:0]    size_log2_q;
  logic [SlotW-1:0]    probe_q, probe_d;
  logic [CntW-1:0]     iter_q, iter_d;
  logic [CntW-1:0]     n_q, n_d;
  logic [SlotW-1:0]    clr_addr_q, clr_addr_d;
  logic                clr_report_q, clr_report_d;
  logic [CntW-1:0]     entry_count_q, entry_count_d;

  // Result registers.
  logic                  done_q, done_d;
  logic                  found_q, found_d;
  logic [SlotW-1:0]      slot_q, slot_d;
  logic [VALUE_BITS-1:0] vout_q, vout_d;
  logic                  status_q, status_d;

  // Captured command fields.
  op_e                   op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  logic                accept;
  logic [SizeW-1:0]    lg_clamped;
  logic [16:0]         pow_w;
  logic [16:0]         n_wide;
  logic [CntW-1:0]     n_now;
  logic [SlotW-1:0]    mask_now;
  logic [SlotW-1:0]    mask_q;
  logic [SlotW-1:0]    probe_next;
  logic                key_match;
  logic                last_probe;
  logic                table_full;
  logic [63:0]         key_wide;
  logic [63:0]         val_wide;
  logic [63:0]         vout_wide;
  logic [31:0]         slot_wide;
  logic [31:0]         count_wide;

  assign accept = start && !busy;

  // Slots in use: 2^log2 with the log2 clamped from below, limited to SLOTS.
  assign lg_clamped = (size_log2_q < SizeLog2Min) ? SizeLog2Min : size_log2_q;
  assign pow_w      = 17'd1 << lg_clamped;
  assign n_wide     = (pow_w > 17'(SLOTS)) ? 17'(SLOTS) : pow_w;
  assign n_now      = n_wide[CntW-1:0];
  assign mask_now   = SlotW'(n_now - CntW'(1));
  assign mask_q     = SlotW'(n_q - CntW'(1));

  // The shared probe adder: slot i+1 is slot i plus i+1, which walks the
  // triangular sequence without a multiplier.
  assign probe_next = (probe_q + iter_q[SlotW-1:0] + SlotW'(1)) & mask_q;
  assign key_match  = (key_rd_q == key_q);
  assign last_probe = ((iter_q + CntW'(1)) == n_q);
  assign table_full = ({entry_count_q, 1'b0} > {1'b0, n_q});

  assign key_wide = 64'(key_i);
  assign val_wide = 64'(value_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= SizeLog2Reset;
    end else if (cfg_we_i) begin
      size_log2_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      key_q <= key_wide[KEY_BITS-1:0];
      val_q <= val_wide[VALUE_BITS-1:0];
    end
  end

  // Memories: one write port and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    occ_rd_q <= occ_mem[probe_q];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      key_mem[probe_q] <= key_q;
    end
    key_rd_q <= key_mem[probe_q];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[probe_q] <= val_q;
    end
    val_rd_q <= val_mem[probe_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      probe_q       <= '0;
      iter_q        <= '0;
      n_q           <= '0;
      clr_addr_q    <= '0;
      clr_report_q  <= 1'b0;
      entry_count_q <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      probe_q       <= probe_d;
      iter_q        <= iter_d;
      n_q           <= n_d;
      clr_addr_q    <= clr_addr_d;
      clr_report_q  <= clr_report_d;
      entry_count_q <= entry_count_d;
      done_q        <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    slot_q   <= slot_d;
    vout_q   <= vout_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d       = state_q;
    probe_d       = probe_q;
    iter_d        = iter_q;
    n_d           = n_q;
    clr_addr_d    = clr_addr_q;
    clr_report_d  = clr_report_q;
    entry_count_d = entry_count_q;
    done_d        = 1'b0;
    found_d       = 1'b0;
    slot_d        = '0;
    vout_d        = '0;
    status_d      = 1'b0;
    occ_we        = 1'b0;
    occ_wa        = probe_q;
    occ_wd        = 1'b0;
    kv_we         = 1'b0;
    val_we        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_LOOKUP, OP_SET: begin
              n_d     = n_now;
              iter_d  = '0;
              probe_d = key_hash_i[SlotW-1:0] & mask_now;
              state_d = ST_READ;
            end
            OP_CLEAR: begin
              clr_addr_d   = '0;
              clr_report_d = 1'b1;
              state_d      = ST_CLEAR;
            end
            default: begin
              // No operation: answer at once with an empty word.
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        occ_we     = 1'b1;
        occ_wa     = clr_addr_q;
        occ_wd     = 1'b0;
        clr_addr_d = clr_addr_q + SlotW'(1);
        if (clr_addr_q == SlotW'(SLOTS - 1)) begin
          entry_count_d = '0;
          done_d        = clr_report_q;
          clr_report_d  = 1'b0;
          state_d       = ST_IDLE;
        end
      end

      ST_READ: begin
        // Memory data for probe_q is registered at the end of this cycle.
        state_d = ST_CHECK;
      end

      ST_CHECK: begin
        if (!occ_rd_q) begin
          // First free slot: the key is absent.
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (op_q == OP_SET) begin
            if (table_full) begin
              status_d = 1'b1;
            end else begin
              occ_we        = 1'b1;
              occ_wa        = probe_q;
              occ_wd        = 1'b1;
              kv_we         = 1'b1;
              val_we        = 1'b1;
              entry_count_d = entry_count_q + CntW'(1);
              slot_d        = probe_q;
              vout_d        = val_q;
            end
          end
        end else if (key_match) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          found_d = 1'b1;
          slot_d  = probe_q;
          if (op_q == OP_SET) begin
            val_we = 1'b1;
            vout_d = val_q;
          end else begin
            vout_d = val_rd_q;
          end
        end else if (last_probe) begin
          // Every probed slot holds another key.
          done_d   = 1'b1;
          state_d  = ST_IDLE;
          status_d = (op_q == OP_SET);
        end else begin
          probe_d = probe_next;
          iter_d  = iter_q + CntW'(1);
          state_d = ST_READ;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign vout_wide  = 64'(vout_q);
  assign slot_wide  = 32'(slot_q);
  assign count_wide = 32'(entry_count_q);

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign found_o        = found_q;
  assign slot_o         = slot_wide[SlotOutW-1:0];
  assign value_out_o    = vout_wide[DataW-1:0];
  assign status_o       = status_q;
  assign stored_count_o = count_wide[CountOutW-1:0];

`ifndef SYNTHESIS
  // A result word only leaves while the sequencer is back at rest.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while the sequencer is busy");

  // The stored count moves by one insert at a time or drops to zero on a clear.
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_count_q != $past(entry_count_q)) |->
      ((entry_count_q == $past(entry_count_q) + CntW'(1)) || (entry_count_q == '0)))
    else $error("stored count changed by more than one insert");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= CntW'(SLOTS))
    else $error("stored count exceeds the slot count");

  // A refused insert never reports a hit.
  a_refuse_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q) |-> (!found_q && (op_q == OP_SET)))
    else $error("table full status on a hit or a non-set word");
`endif

endmodule

`default_nettype wire
